>>> hdl/dciq_pkg.sv
// ----------------------------------------------------------------------------
// dciq_pkg
// Shared constants, codes and the result type of the DC / IQ correction
// search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dciq_pkg;

  // Item kinds on the input stream.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Search stages, as reported on the result stream.
  localparam logic [1:0] ST_DC   = 2'd0;
  localparam logic [1:0] ST_IQ   = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Four passes per stage: coarse even arm, coarse odd arm, then fine.
  localparam logic [1:0] PASS_FIRST_FINE = 2'd2;
  localparam logic [1:0] PASS_LAST       = 2'd3;

  // Search geometry.
  localparam int DC_SCALE_RX = 64;
  localparam int DC_SCALE_TX = 128;
  localparam int IQ_SPAN     = 512;
  localparam int COARSE_STEP = 8;
  localparam int FINE_HALF   = 8;
  localparam int GAIN_FULL   = 2047;

  // Signed working width of trial codes: holds +-IQ_SPAN plus a step.
  localparam int IDX_W  = $clog2(IQ_SPAN) + 3;
  localparam int STEP_W = $clog2(COARSE_STEP + 1);

  localparam int LEVEL_W = 16;
  localparam int DC_W    = 8;
  localparam int IQ_W    = 10;
  localparam int GW_W    = 11;

  // Configuration register map (word index from byte address bit 2).
  localparam logic REG_TX_MODE = 1'b0;

  typedef struct packed {
    logic              done_res;
    logic [GW_W-1:0]   gain_word_q;
    logic [GW_W-1:0]   gain_word_i;
    logic signed [IQ_W-1:0] trial_phase_corr;
    logic signed [IQ_W-1:0] trial_gain_corr;
    logic signed [DC_W-1:0] trial_dc_q;
    logic signed [DC_W-1:0] trial_dc_i;
    logic [1:0]        stage;
  } dciq_result_t;

endpackage

`default_nettype wire

>>> hdl/dc_iq_correction_search_top.sv
// ----------------------------------------------------------------------------
// dc_iq_correction_search_top
// Coarse-to-fine coordinate search sequencer for DC offset and IQ
// imbalance calibration, with stream ports and an APB register port.
// ----------------------------------------------------------------------------
// A result transaction passes through the input register, then the result
// register, before it is valid on the result stream.
// Throughput: one transaction per cycle while the result stream does not
// stall; the dciq_core state update between the two registers sets that figure.
// Reset (synchronous, active high) leaves the search done with all best codes
// at zero, tx_mode at zero and both stream stages empty.
`default_nettype none

module dc_iq_correction_search_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] level (signed Q8.8 dB)
  input  wire logic        s_axis_tuser,   // [0] opcode
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] trial_dc_i, [15:8] trial_dc_q, [25:16] trial_gain_corr,
  // [35:26] trial_phase_corr, [46:36] gain_word_i, [57:47] gain_word_q,
  // [63:58] zero
  output logic [63:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,   // [1:0] stage, [2] done_res
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import dciq_pkg::*;

  // Configuration register. Only the word index (address bit 2) is decoded.
  logic tx_mode;

  // Input register stage.
  logic                      in_valid;
  logic                      in_opcode;
  logic signed [LEVEL_W-1:0] in_level;

  // Result register stage.
  logic                      out_valid;
  dciq_result_t              out_res;

  logic                      advance;
  dciq_result_t              core_res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TX_MODE)) begin
      tx_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TX_MODE) begin
      prdata[0] = tx_mode;
    end
  end

  // The held item is processed when the result register is free or is being
  // emptied in the same cycle; the input stage then refills at once.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_opcode <= s_axis_tuser;
      in_level  <= s_axis_tdata;
    end
  end

  dciq_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (advance),
    .opcode     (in_opcode),
    .level      (in_level),
    .tx_mode    (tx_mode),
    .result     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0,
                          out_res.gain_word_q,
                          out_res.gain_word_i,
                          out_res.trial_phase_corr,
                          out_res.trial_gain_corr,
                          out_res.trial_dc_q,
                          out_res.trial_dc_i};
  assign m_axis_tuser  = {out_res.done_res, out_res.stage};

endmodule

`default_nettype wire

>>> hdl/dciq_core.sv
// ----------------------------------------------------------------------------
// dciq_core
// Search state and the combinational update that turns one item into the
// next trial setting.
// ----------------------------------------------------------------------------
`default_nettype none

module dciq_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  input  wire logic                         opcode,
  input  wire logic signed [15:0]           level,
  input  wire logic                         tx_mode,
  output dciq_pkg::dciq_result_t            result
);

  import dciq_pkg::*;

  // Search state.
  logic [1:0]                search_stage, search_stage_next;
  logic [1:0]                pass_number, pass_number_next;
  logic signed [IDX_W-1:0]   trial_index, trial_index_next;
  logic signed [IDX_W-1:0]   pass_stop, pass_stop_next;
  logic [STEP_W-1:0]         pass_step, pass_step_next;
  logic signed [DC_W-1:0]    best_dc_i, best_dc_i_next;
  logic signed [DC_W-1:0]    best_dc_q, best_dc_q_next;
  logic signed [IQ_W-1:0]    best_gain, best_gain_next;
  logic signed [IQ_W-1:0]    best_phase, best_phase_next;
  logic signed [LEVEL_W-1:0] min_level, min_level_next;

  // Working values.
  logic                      start_pass;
  logic signed [IDX_W-1:0]   step_ext;
  logic signed [IDX_W-1:0]   idx_sum;
  logic signed [IDX_W-1:0]   span;
  logic signed [IDX_W-1:0]   neg_span;
  logic signed [IDX_W-1:0]   center;
  logic signed [IDX_W-1:0]   lo_fine;
  logic signed [IDX_W-1:0]   hi_fine;
  logic signed [DC_W-1:0]    cur_di, cur_dq, out_di, out_dq;
  logic signed [IQ_W-1:0]    cur_g, cur_p, out_g, out_p;

  localparam logic signed [IDX_W-1:0] HALF_W = IDX_W'(FINE_HALF);
  localparam logic signed [IDX_W-1:0] ONE_W  = IDX_W'(1);

  // Trial applied for the current state; the measurement refers to it.
  always_comb begin
    cur_di = best_dc_i;
    cur_dq = best_dc_q;
    cur_g  = best_gain;
    cur_p  = best_phase;
    if (search_stage == ST_DC) begin
      cur_g = '0;
      cur_p = '0;
      if (!pass_number[0]) begin
        cur_dq = trial_index[DC_W-1:0];
      end else begin
        cur_di = trial_index[DC_W-1:0];
      end
    end else begin
      if (!pass_number[0]) begin
        cur_g = trial_index[IQ_W-1:0];
      end else begin
        cur_p = trial_index[IQ_W-1:0];
      end
    end
  end

  assign step_ext = $signed({{(IDX_W-STEP_W){1'b0}}, pass_step});
  assign idx_sum  = trial_index + step_ext;

  // Next state.
  always_comb begin
    search_stage_next = search_stage;
    pass_number_next  = pass_number;
    trial_index_next  = trial_index;
    pass_stop_next    = pass_stop;
    pass_step_next    = pass_step;
    best_dc_i_next    = best_dc_i;
    best_dc_q_next    = best_dc_q;
    best_gain_next    = best_gain;
    best_phase_next   = best_phase;
    min_level_next    = min_level;
    start_pass        = 1'b0;
    span              = '0;
    neg_span          = '0;
    center            = '0;
    lo_fine           = '0;
    hi_fine           = '0;

    if (opcode == OP_START) begin
      search_stage_next = ST_DC;
      pass_number_next  = '0;
      best_dc_i_next    = '0;
      best_dc_q_next    = '0;
      best_gain_next    = '0;
      best_phase_next   = '0;
      min_level_next    = '0;
      start_pass        = 1'b1;
    end else if (!search_stage[1]) begin
      if (level < min_level) begin
        min_level_next = level;
        if (search_stage == ST_DC) begin
          best_dc_i_next = cur_di;
          best_dc_q_next = cur_dq;
        end else begin
          best_gain_next  = cur_g;
          best_phase_next = cur_p;
        end
      end
      if (idx_sum < pass_stop) begin
        trial_index_next = idx_sum;
      end else if (pass_number == PASS_LAST) begin
        pass_number_next = '0;
        if (search_stage == ST_DC) begin
          search_stage_next = ST_IQ;
          min_level_next    = '0;
          start_pass        = 1'b1;
        end else begin
          search_stage_next = ST_DONE;
        end
      end else begin
        pass_number_next = pass_number + 2'd1;
        start_pass       = 1'b1;
      end
    end

    // Set up the bounds of a new pass from the updated state.
    if (start_pass) begin
      if (search_stage_next == ST_DC) begin
        span = tx_mode ? IDX_W'(DC_SCALE_TX) : IDX_W'(DC_SCALE_RX);
      end else begin
        span = IDX_W'(IQ_SPAN);
      end
      neg_span = -span;
      if (pass_number_next == PASS_FIRST_FINE) begin
        min_level_next = '0;
      end
      if (pass_number_next[1]) begin
        if (search_stage_next == ST_DC) begin
          center = !pass_number_next[0]
                 ? IDX_W'(best_dc_q_next) : IDX_W'(best_dc_i_next);
        end else begin
          center = !pass_number_next[0]
                 ? IDX_W'(best_gain_next) : IDX_W'(best_phase_next);
        end
        if (center < neg_span) begin
          center = neg_span;
        end
        if (center > span - ONE_W) begin
          center = span - ONE_W;
        end
        lo_fine = center - HALF_W;
        hi_fine = center + HALF_W;
        trial_index_next = (lo_fine > neg_span) ? lo_fine : neg_span;
        pass_stop_next   = (hi_fine < span) ? hi_fine : span;
        pass_step_next   = STEP_W'(1);
      end else begin
        trial_index_next = neg_span;
        pass_stop_next   = span;
        pass_step_next   = STEP_W'(COARSE_STEP);
      end
    end
  end

  // Result from the updated state.
  always_comb begin
    out_di = best_dc_i_next;
    out_dq = best_dc_q_next;
    out_g  = best_gain_next;
    out_p  = best_phase_next;
    if (search_stage_next == ST_DC) begin
      out_g = '0;
      out_p = '0;
      if (!pass_number_next[0]) begin
        out_dq = trial_index_next[DC_W-1:0];
      end else begin
        out_di = trial_index_next[DC_W-1:0];
      end
    end else if (search_stage_next == ST_IQ) begin
      if (!pass_number_next[0]) begin
        out_g = trial_index_next[IQ_W-1:0];
      end else begin
        out_p = trial_index_next[IQ_W-1:0];
      end
    end

    result.stage            = search_stage_next[1] ? ST_DONE : search_stage_next;
    result.done_res         = search_stage_next[1];
    result.trial_dc_i       = out_di;
    result.trial_dc_q       = out_dq;
    result.trial_gain_corr  = out_g;
    result.trial_phase_corr = out_p;
    result.gain_word_i      = out_g[IQ_W-1]
                            ? GW_W'(GAIN_FULL) + {out_g[IQ_W-1], out_g}
                            : GW_W'(GAIN_FULL);
    result.gain_word_q      = (!out_g[IQ_W-1] && (out_g != '0))
                            ? GW_W'(GAIN_FULL) - {out_g[IQ_W-1], out_g}
                            : GW_W'(GAIN_FULL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_stage <= ST_DONE;
      pass_number  <= '0;
      trial_index  <= '0;
      pass_stop    <= '0;
      pass_step    <= STEP_W'(COARSE_STEP);
      best_dc_i    <= '0;
      best_dc_q    <= '0;
      best_gain    <= '0;
      best_phase   <= '0;
      min_level    <= '0;
    end else if (item_valid) begin
      search_stage <= search_stage_next;
      pass_number  <= pass_number_next;
      trial_index  <= trial_index_next;
      pass_stop    <= pass_stop_next;
      pass_step    <= pass_step_next;
      best_dc_i    <= best_dc_i_next;
      best_dc_q    <= best_dc_q_next;
      best_gain    <= best_gain_next;
      best_phase   <= best_phase_next;
      min_level    <= min_level_next;
    end
  end

endmodule

`default_nettype wire
